// ===== src/wsd_pkg.sv =====
package wsd_pkg;

  // Fixed field widths
  localparam int GAIN_W     = 16;
  localparam int BASE_W     = 7;
  localparam int MODE_W     = 2;
  localparam int DELTA_W    = 8;
  localparam int DRIVE_W    = 8;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  // Drive level limit, also the left speed range
  localparam int SPEED_LIMIT = 100;

  // Parameter defaults
  localparam int TOTAL_BITS_DEF     = 16;
  localparam int GAIN_FRAC_BITS_DEF = 12;

  // Register reset values
  localparam logic [GAIN_W-1:0] GAIN_PROP_RST  = 16'd6881;
  localparam logic [GAIN_W-1:0] GAIN_INTEG_RST = 16'd913;
  localparam logic [BASE_W-1:0] BASE_SPEED_RST = 7'd50;
  localparam logic [15:0]       TARGET_RST     = 16'd0;

  typedef enum logic [MODE_W-1:0] {
    MODE_FWD   = 2'd0,
    MODE_REV   = 2'd1,
    MODE_ROT_L = 2'd2,
    MODE_ROT_R = 2'd3
  } move_mode_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_GAIN_PROP    = 3'd0,
    REG_GAIN_INTEG   = 3'd1,
    REG_BASE_SPEED   = 3'd2,
    REG_TARGET_TICKS = 3'd3,
    REG_MOVE_MODE    = 3'd4
  } cfg_reg_t;

endpackage

// ===== src/wsd_sample_if.sv =====
interface wsd_sample_if
  import wsd_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               start_req;
  logic [DELTA_W-1:0] left_delta;
  logic [DELTA_W-1:0] right_delta;

  modport source (output valid, start_req, left_delta, right_delta, input ready);
  modport sink   (input valid, start_req, left_delta, right_delta, output ready);
endinterface

// ===== src/wsd_drive_if.sv =====
interface wsd_drive_if
  import wsd_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] left_drive;
  logic signed [DRIVE_W-1:0] right_drive;
  logic                      done_res;

  modport source (output valid, left_drive, right_drive, done_res, input ready);
  modport sink   (input valid, left_drive, right_drive, done_res, output ready);
endinterface

// ===== src/wsd_term.sv =====
// Gain times signed error, shifted down with truncation toward zero.
module wsd_term
  import wsd_pkg::*;
#(
  parameter int ERR_W          = DELTA_W + 1,
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
  localparam int PROD_W        = GAIN_W + ERR_W,
  localparam int TERM_W        = PROD_W - GAIN_FRAC_BITS + 1
) (
  input  logic        [GAIN_W-1:0] gain,
  input  logic signed [ERR_W-1:0]  err,
  output logic signed [TERM_W-1:0] term
);

  logic                                 neg;
  logic [ERR_W-1:0]                     mag;
  logic [PROD_W-1:0]                    prod;
  logic [PROD_W-GAIN_FRAC_BITS-1:0]     scaled;

  assign neg    = err[ERR_W-1];
  assign mag    = neg ? ERR_W'(-err) : ERR_W'(err);
  assign prod   = PROD_W'(gain) * PROD_W'(mag);
  assign scaled = prod[PROD_W-1:GAIN_FRAC_BITS];
  assign term   = neg ? -$signed({1'b0, scaled}) : $signed({1'b0, scaled});

endmodule

// ===== src/wheel_sync_pi_drive.sv =====
// Channel   Dir  Payload                                  Transfer when
// samp      in   start_req, left_delta, right_delta       samp.valid & samp.ready
// drv       out  left_drive, right_drive, done_res        drv.valid & drv.ready
// cfg       in   cfg_addr (register), cfg_data            cfg_we
//
// From sample transfer to result: the sample register, then the PI
// update (two multipliers, add, saturate) into the result register.
// One sample per cycle while drv is ready; the PI update path sets the clock limit.
// Synchronous reset: totals and speed cleared, no move running, registers
// to their defaults, both channels empty.
// A stalled result holds; one more sample is still taken into the sample
// register behind it, then samp.ready drops until drv frees.
module wheel_sync_pi_drive
  import wsd_pkg::*;
#(
  parameter int TOTAL_BITS     = TOTAL_BITS_DEF,
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  wsd_sample_if.sink            samp,
  wsd_drive_if.source           drv,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PERR_W = DELTA_W + 1;
  localparam int IERR_W = TOTAL_BITS + 1;
  localparam int PTERM_W = GAIN_W + PERR_W - GAIN_FRAC_BITS + 1;
  localparam int ITERM_W = GAIN_W + IERR_W - GAIN_FRAC_BITS + 1;
  localparam int SUM_W   = GAIN_W + TOTAL_BITS + 4;
  localparam int CMP_W   = (TOTAL_BITS > 16) ? TOTAL_BITS : 16;

  // ---- configuration registers ----
  logic [GAIN_W-1:0] gain_prop;
  logic [GAIN_W-1:0] gain_integ;
  logic [BASE_W-1:0] base_speed;
  logic [15:0]       target_ticks;
  move_mode_t        move_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_prop    <= GAIN_PROP_RST;
      gain_integ   <= GAIN_INTEG_RST;
      base_speed   <= BASE_SPEED_RST;
      target_ticks <= TARGET_RST;
      move_mode    <= MODE_FWD;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_GAIN_PROP:    gain_prop    <= cfg_data[GAIN_W-1:0];
        REG_GAIN_INTEG:   gain_integ   <= cfg_data[GAIN_W-1:0];
        REG_BASE_SPEED:   base_speed   <= cfg_data[BASE_W-1:0];
        REG_TARGET_TICKS: target_ticks <= cfg_data[15:0];
        REG_MOVE_MODE:    move_mode    <= move_mode_t'(cfg_data[MODE_W-1:0]);
        default: ;  // unused indexes ignored
      endcase
    end
  end

  // ---- handshake ----
  logic s1_valid;
  logic s1_start;
  logic [DELTA_W-1:0] s1_ld;
  logic [DELTA_W-1:0] s1_rd;
  logic out_valid;
  logic out_free;
  logic fire;

  assign out_free   = !out_valid || drv.ready;
  assign fire       = s1_valid && out_free;
  assign samp.ready = !s1_valid || out_free;
  assign drv.valid  = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (samp.ready) begin
      s1_valid <= samp.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samp.valid && samp.ready) begin
      s1_start <= samp.start_req;
      s1_ld    <= samp.left_delta;
      s1_rd    <= samp.right_delta;
    end
  end

  // ---- move state ----
  logic [TOTAL_BITS-1:0]     left_total;
  logic [TOTAL_BITS-1:0]     right_total;
  logic signed [DRIVE_W-1:0] left_speed;
  logic                      finished;

  // ---- PI update ----
  logic [BASE_W-1:0]         base_lim;
  logic signed [DRIVE_W-1:0] base_drv;
  logic [TOTAL_BITS-1:0]     lt_start, rt_start;
  logic signed [DRIVE_W-1:0] speed_init;
  logic                      fin_start;
  logic [TOTAL_BITS:0]       lt_sum, rt_sum;
  logic [TOTAL_BITS-1:0]     lt_upd, rt_upd;
  logic signed [PERR_W-1:0]  err_live;
  logic signed [IERR_W-1:0]  err_tot;
  logic signed [PTERM_W-1:0] p_term;
  logic signed [ITERM_W-1:0] i_term;
  logic signed [SUM_W-1:0]   sp;
  logic signed [DRIVE_W-1:0] speed_upd;
  logic [TOTAL_BITS-1:0]     left_total_next, right_total_next;
  logic signed [DRIVE_W-1:0] left_speed_next;
  logic                      finished_next;
  logic signed [DRIVE_W-1:0] ldrv_next, rdrv_next;

  assign base_lim = (base_speed > BASE_W'(SPEED_LIMIT)) ? BASE_W'(SPEED_LIMIT) : base_speed;
  assign base_drv = $signed({1'b0, base_lim});

  // start applies first; the same sample's deltas count toward the new move
  assign lt_start    = s1_start ? '0 : left_total;
  assign rt_start    = s1_start ? '0 : right_total;
  assign speed_init  = s1_start ? base_drv : left_speed;
  assign fin_start   = s1_start ? 1'b0 : finished;

  // saturating tick totals
  assign lt_sum = {1'b0, lt_start} + (TOTAL_BITS+1)'(s1_ld);
  assign rt_sum = {1'b0, rt_start} + (TOTAL_BITS+1)'(s1_rd);
  assign lt_upd = lt_sum[TOTAL_BITS] ? '1 : lt_sum[TOTAL_BITS-1:0];
  assign rt_upd = rt_sum[TOTAL_BITS] ? '1 : rt_sum[TOTAL_BITS-1:0];

  assign err_live = $signed({1'b0, s1_rd}) - $signed({1'b0, s1_ld});
  assign err_tot  = $signed({1'b0, rt_upd}) - $signed({1'b0, lt_upd});

  wsd_term #(
    .ERR_W          (PERR_W),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_p_term (
    .gain (gain_prop),
    .err  (err_live),
    .term (p_term)
  );

  wsd_term #(
    .ERR_W          (IERR_W),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_i_term (
    .gain (gain_integ),
    .err  (err_tot),
    .term (i_term)
  );

  assign sp = SUM_W'(speed_init) + SUM_W'(p_term) + SUM_W'(i_term);

  always_comb begin
    if (sp > SUM_W'(SPEED_LIMIT)) begin
      speed_upd = DRIVE_W'(SPEED_LIMIT);
    end else if (sp < -SUM_W'(SPEED_LIMIT)) begin
      speed_upd = -DRIVE_W'(SPEED_LIMIT);
    end else begin
      speed_upd = sp[DRIVE_W-1:0];
    end
  end

  // state holds while no move runs
  always_comb begin
    if (fin_start) begin
      left_total_next  = lt_start;
      right_total_next = rt_start;
      left_speed_next  = speed_init;
      finished_next    = 1'b1;
    end else begin
      left_total_next  = lt_upd;
      right_total_next = rt_upd;
      left_speed_next  = speed_upd;
      finished_next    = CMP_W'(lt_upd) >= CMP_W'(target_ticks);
    end
  end

  // wheel signs by mode; zero drive once done
  always_comb begin
    ldrv_next = '0;
    rdrv_next = '0;
    if (!finished_next) begin
      case (move_mode)
        MODE_FWD: begin
          ldrv_next = left_speed_next;
          rdrv_next = base_drv;
        end
        MODE_REV: begin
          ldrv_next = -left_speed_next;
          rdrv_next = -base_drv;
        end
        MODE_ROT_L: begin
          ldrv_next = -left_speed_next;
          rdrv_next = base_drv;
        end
        default: begin
          ldrv_next = left_speed_next;
          rdrv_next = -base_drv;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_total  <= '0;
      right_total <= '0;
      left_speed  <= '0;
      finished    <= 1'b1;
    end else if (fire) begin
      left_total  <= left_total_next;
      right_total <= right_total_next;
      left_speed  <= left_speed_next;
      finished    <= finished_next;
    end
  end

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      drv.left_drive  <= ldrv_next;
      drv.right_drive <= rdrv_next;
      drv.done_res    <= finished_next;
    end
  end

  // ---- checks ----
  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    drv.valid && drv.done_res |-> drv.left_drive == '0 && drv.right_drive == '0)
    else $error("done result with nonzero drive");

  a_speed_range: assert property (@(posedge clk) disable iff (rst)
    left_speed <= DRIVE_W'(SPEED_LIMIT) && left_speed >= -DRIVE_W'(SPEED_LIMIT))
    else $error("left speed out of range");

  a_fire_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("update fired without a result");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> finished && !out_valid && !s1_valid)
    else $error("not idle after reset");

endmodule
